[src/imu_frame_parser_top_assert.svh]
// ----------------------------------------------------------------------------
// IMU frame parser assertion macros
// Shared property forms for the checker bound to the top level.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_TOP_ASSERT_SVH
`define IMU_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define IMUFP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("imufp check failed");

// next-cycle implication
`define IMUFP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("imufp check failed");

`endif

[src/imufp_pkg.sv]
// ----------------------------------------------------------------------------
// IMU frame parser package
// Types and fixed constants shared by the parser modules.
// ----------------------------------------------------------------------------
package imufp_pkg;

    localparam int CAPTURE_LEN = 12;
    localparam int CAP_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SYNC_RESET = 8'h5A;
    localparam int TYPE_RATES_BIT  = 2;
    localparam int TYPE_ANGLES_BIT = 3;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_SYNC_VALUE = 1'b0;

    typedef logic [CAPTURE_LEN-1:0][7:0] cap_t;

    typedef struct packed {
        logic rates;
        logic angles;
        cap_t cap;
    } rec_t;

endpackage

[src/imufp_if.sv]
// ----------------------------------------------------------------------------
// IMU frame parser channels
// Byte input channel and decoded frame result channel.
// ----------------------------------------------------------------------------
interface imufp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface imufp_result_if;
    logic               valid;
    logic               ready;
    logic               rates_updated;
    logic               angles_updated;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [15:0]        yaw_centideg;
    logic signed [15:0] roll_centideg;
    logic signed [15:0] pitch_centideg;
    logic [15:0]        good_frames;

    modport source (
        output valid, input ready,
        output rates_updated, output angles_updated,
        output rate_x, output rate_y, output rate_z,
        output yaw_centideg, output roll_centideg, output pitch_centideg,
        output good_frames
    );
    modport sink (
        input valid, output ready,
        input rates_updated, input angles_updated,
        input rate_x, input rate_y, input rate_z,
        input yaw_centideg, input roll_centideg, input pitch_centideg,
        input good_frames
    );
endinterface

[src/imufp_fifo.sv]
// ----------------------------------------------------------------------------
// IMU frame parser record queue
// Short queue of good-frame records between the parser and the result stage.
// ----------------------------------------------------------------------------
module imufp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  imufp_pkg::rec_t    wr_data,
    input  logic               pop,
    output imufp_pkg::rec_t    rd_data,
    output logic               full,
    output logic               empty
);

    localparam int PTR_W = $clog2(imufp_pkg::QUEUE_DEPTH);

    imufp_pkg::rec_t        mem_reg [imufp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W:0]         count_reg;

    assign full    = (count_reg == (PTR_W+1)'(imufp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/imufp_front.sv]
// ----------------------------------------------------------------------------
// IMU frame parser front end
// Sync hunt, header and payload capture, checksum test; queues good frames.
// ----------------------------------------------------------------------------
module imufp_front #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    imufp_byte_if.sink        rx,
    input  logic [7:0]        sync_value,
    input  logic              queue_full,
    output logic              push,
    output imufp_pkg::rec_t   rec
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_inc;
    logic             rates_reg, rates_next;
    logic             angles_reg, angles_next;
    logic [7:0]       sum_reg, sum_next;
    imufp_pkg::cap_t  cap_reg, cap_next;
    logic             beat;
    logic [7:0]       b;

    assign rx.ready = !queue_full;
    assign beat     = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign pos_inc  = pos_reg + 1'b1;

    assign rec.rates  = rates_reg;
    assign rec.angles = angles_reg;
    assign rec.cap    = cap_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        rates_next  = rates_reg;
        angles_next = angles_reg;
        sum_next    = sum_reg;
        cap_next    = cap_reg;
        push        = 1'b0;
        if (beat)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (b == sync_value)
                    begin
                        cap_next   = '0;
                        sum_next   = b;
                        pos_next   = '0;
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (b == sync_value)
                    begin
                        sum_next   = sum_reg + b;
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_TYPE:
                begin
                    rates_next  = b[imufp_pkg::TYPE_RATES_BIT];
                    angles_next = b[imufp_pkg::TYPE_ANGLES_BIT];
                    sum_next    = sum_reg + b;
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    if ({1'b0, b} > 9'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        len_next   = b[POS_W-1:0];
                        sum_next   = sum_reg + b;
                        pos_next   = '0;
                        phase_next = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (pos_reg < POS_W'(imufp_pkg::CAPTURE_LEN))
                    begin
                        cap_next[pos_reg[imufp_pkg::CAP_IDX_W-1:0]] = b;
                    end
                    sum_next = sum_reg + b;
                    pos_next = pos_inc;
                    if (pos_inc >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_SYNC1;
                    push       = (b == sum_reg);
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            pos_reg    <= '0;
            len_reg    <= '0;
            rates_reg  <= 1'b0;
            angles_reg <= 1'b0;
            sum_reg    <= '0;
            cap_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            rates_reg  <= rates_next;
            angles_reg <= angles_next;
            sum_reg    <= sum_next;
            cap_reg    <= cap_next;
        end
    end

endmodule

[src/imufp_back.sv]
// ----------------------------------------------------------------------------
// IMU frame parser result stage
// Loads held rates and angles from queued frames, counts, drives results.
// ----------------------------------------------------------------------------
module imufp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  imufp_pkg::rec_t   rec,
    output logic              pop,
    imufp_result_if.source    frame
);

    logic        valid_reg;
    logic        rates_upd_reg;
    logic        angles_upd_reg;
    logic [15:0] rate_x_reg;
    logic [15:0] rate_y_reg;
    logic [15:0] rate_z_reg;
    logic [15:0] yaw_reg;
    logic [15:0] roll_reg;
    logic [15:0] pitch_reg;
    logic [15:0] count_reg;

    assign pop = !queue_empty && (!valid_reg || frame.ready);

    assign frame.valid          = valid_reg;
    assign frame.rates_updated  = rates_upd_reg;
    assign frame.angles_updated = angles_upd_reg;
    assign frame.rate_x         = rate_x_reg;
    assign frame.rate_y         = rate_y_reg;
    assign frame.rate_z         = rate_z_reg;
    assign frame.yaw_centideg   = yaw_reg;
    assign frame.roll_centideg  = roll_reg;
    assign frame.pitch_centideg = pitch_reg;
    assign frame.good_frames    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            rates_upd_reg  <= 1'b0;
            angles_upd_reg <= 1'b0;
            rate_x_reg     <= '0;
            rate_y_reg     <= '0;
            rate_z_reg     <= '0;
            yaw_reg        <= '0;
            roll_reg       <= '0;
            pitch_reg      <= '0;
            count_reg      <= '0;
        end
        else if (pop)
        begin
            valid_reg      <= 1'b1;
            rates_upd_reg  <= rec.rates;
            angles_upd_reg <= rec.angles;
            if (rec.rates)
            begin
                rate_x_reg <= {rec.cap[0], rec.cap[1]};
                rate_y_reg <= {rec.cap[2], rec.cap[3]};
                rate_z_reg <= {rec.cap[4], rec.cap[5]};
            end
            if (rec.angles)
            begin
                yaw_reg   <= {rec.cap[6], rec.cap[7]};
                roll_reg  <= {rec.cap[8], rec.cap[9]};
                pitch_reg <= {rec.cap[10], rec.cap[11]};
            end
            count_reg <= count_reg + 16'd1;
        end
        else if (frame.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

[src/imu_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// IMU frame parser top level
// Serial byte stream in, one decoded result per good frame out.
// ----------------------------------------------------------------------------
// Channel rx carries one received byte per beat; channel frame carries one
// result per frame whose checksum matches. The APB port holds the sync byte
// value at address 0 (reset 0x5A); write it only while no frame is open.
// Throughput: one byte per cycle, set by the parser state update. rx stalls
// only when the two-entry record queue is full, which happens only while
// frame is held back by its receiver.
// The checksum byte beat writes the record into the queue; frame.valid rises
// when that record is popped into the output register, once that is free.
// A stalled result holds its fields; the held rates and angles change only
// when the next queued record is loaded into the output register.
// Reset clears the parser to sync hunt, the queue, the held fields and the
// good-frame count.
// ----------------------------------------------------------------------------
module imu_frame_parser_top #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    imufp_byte_if.sink                        rx,
    imufp_result_if.source                    frame,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imufp_pkg::ADDR_W-1:0]      paddr,
    input  logic [imufp_pkg::DATA_W-1:0]      pwdata,
    output logic [imufp_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);

    logic            sync_reg;
    logic [7:0]      sync_value_reg;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;
    imufp_pkg::rec_t wr_rec;
    imufp_pkg::rec_t rd_rec;

    assign pready   = 1'b1;
    assign sync_reg = (paddr[imufp_pkg::ADDR_W-1] == imufp_pkg::REG_SYNC_VALUE);
    assign prdata   = sync_reg ? {{(imufp_pkg::DATA_W-8){1'b0}}, sync_value_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= imufp_pkg::SYNC_RESET;
        end
        else if (psel && penable && pwrite && pready && sync_reg)
        begin
            sync_value_reg <= pwdata[7:0];
        end
    end

    imufp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .sync_value (sync_value_reg),
        .queue_full (queue_full),
        .push       (push),
        .rec        (wr_rec)
    );

    imufp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_rec),
        .pop     (pop),
        .rd_data (rd_rec),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    imufp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .rec         (rd_rec),
        .pop         (pop),
        .frame       (frame)
    );

endmodule

[src/imufp_chk.sv]
// ----------------------------------------------------------------------------
// IMU frame parser port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "imu_frame_parser_top_assert.svh"

module imufp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic        rates_updated,
    input logic        angles_updated,
    input logic [15:0] rate_x,
    input logic [15:0] rate_y,
    input logic [15:0] rate_z,
    input logic [15:0] yaw_centideg,
    input logic [15:0] roll_centideg,
    input logic [15:0] pitch_centideg,
    input logic [15:0] good_frames
);

    logic        seen_reg;
    logic [15:0] count_reg;
    logic [47:0] rates_reg;
    logic [47:0] angles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            count_reg  <= '0;
            rates_reg  <= '0;
            angles_reg <= '0;
        end
        else if (valid && ready)
        begin
            seen_reg   <= 1'b1;
            count_reg  <= good_frames;
            rates_reg  <= {rate_x, rate_y, rate_z};
            angles_reg <= {yaw_centideg, roll_centideg, pitch_centideg};
        end
    end

    `IMUFP_ASSERT_NXT(a_stall_hold, clk, rst_n, valid && !ready,
        valid && $stable(good_frames) && $stable(rate_x) && $stable(yaw_centideg))
    `IMUFP_ASSERT_IMP(a_count_step, clk, rst_n, valid && seen_reg,
        good_frames == count_reg + 16'd1)
    `IMUFP_ASSERT_IMP(a_rates_held, clk, rst_n, valid && seen_reg && !rates_updated,
        {rate_x, rate_y, rate_z} == rates_reg)
    `IMUFP_ASSERT_IMP(a_angles_held, clk, rst_n, valid && seen_reg && !angles_updated,
        {yaw_centideg, roll_centideg, pitch_centideg} == angles_reg)

endmodule

bind imu_frame_parser_top imufp_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (frame.valid),
    .ready          (frame.ready),
    .rates_updated  (frame.rates_updated),
    .angles_updated (frame.angles_updated),
    .rate_x         (frame.rate_x),
    .rate_y         (frame.rate_y),
    .rate_z         (frame.rate_z),
    .yaw_centideg   (frame.yaw_centideg),
    .roll_centideg  (frame.roll_centideg),
    .pitch_centideg (frame.pitch_centideg),
    .good_frames    (frame.good_frames)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU frame parser testbench
// Drives framed and noisy byte streams into the parser, tracks the expected
// decoded results with a behavioral parser, and checks every result beat
// field by field under sender gaps, receiver stalls and sync value changes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ADDR_W      = imufp_pkg::ADDR_W;
    localparam int DATA_W      = imufp_pkg::DATA_W;
    localparam int CAPTURE_LEN = imufp_pkg::CAPTURE_LEN;
    localparam int MAX_LEN     = 16;
    localparam int LIMIT       = 2_000_000;
    localparam int SETTLE      = 8;
    localparam int MAX_REPORT  = 10;
    localparam logic [ADDR_W-1:0] SYNC_ADDR =
        ADDR_W'(4 * int'(imufp_pkg::REG_SYNC_VALUE));

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } hunt_phase_t;

    typedef struct packed {
        logic               rates;
        logic               angles;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [15:0]        yaw;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [15:0]        count;
    } frame_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    imufp_byte_if   rx_ch ();
    imufp_result_if frame_ch ();

    imu_frame_parser_top #(
        .MAX_PAYLOAD(MAX_LEN)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_ch),
        .frame(frame_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // parser shadow state
    logic [7:0]  sync_cfg;
    hunt_phase_t ph;
    logic [7:0]  pos;
    logic [7:0]  plen;
    logic [7:0]  ftype_held;
    logic [7:0]  csum;
    logic [7:0]  cap_bytes [CAPTURE_LEN];
    logic [15:0] held_rate [3];
    logic [15:0] held_angle [3];
    logic [15:0] good_count;

    frame_result_t expected_frames [$];
    logic [7:0]    body_buf [MAX_LEN];

    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_left;
    int mismatch_count;
    int bytes_sent;
    int frames_seen;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function void reset_tracker();
        sync_cfg   = imufp_pkg::SYNC_RESET;
        ph         = PH_HUNT1;
        pos        = '0;
        plen       = '0;
        ftype_held = '0;
        csum       = '0;
        good_count = '0;
        foreach (cap_bytes[i])
            cap_bytes[i] = '0;
        for (int k = 0; k < 3; k++)
        begin
            held_rate[k]  = '0;
            held_angle[k] = '0;
        end
    endfunction

    function void track_byte(input logic [7:0] b);
        frame_result_t r;
        r = '0;
        case (ph)
            PH_HUNT1:
                if (b == sync_cfg)
                begin
                    foreach (cap_bytes[i])
                        cap_bytes[i] = '0;
                    csum = b;
                    pos  = '0;
                    ph   = PH_HUNT2;
                end
            PH_HUNT2:
                if (b == sync_cfg)
                begin
                    csum = csum + b;
                    ph   = PH_TYPE;
                end
                else
                    ph = PH_HUNT1;
            PH_TYPE:
            begin
                ftype_held = b;
                csum       = csum + b;
                ph         = PH_LEN;
            end
            PH_LEN:
                if (int'(b) > MAX_LEN)
                    ph = PH_HUNT1;
                else
                begin
                    plen = b;
                    csum = csum + b;
                    pos  = '0;
                    ph   = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            PH_PAYLOAD:
            begin
                if (int'(pos) < CAPTURE_LEN)
                    cap_bytes[pos[3:0]] = b;
                csum = csum + b;
                pos  = pos + 8'd1;
                if (pos >= plen)
                    ph = PH_CHECK;
            end
            PH_CHECK:
            begin
                ph = PH_HUNT1;
                if (b == csum)
                begin
                    if (ftype_held[imufp_pkg::TYPE_RATES_BIT])
                    begin
                        for (int k = 0; k < 3; k++)
                            held_rate[k] = {cap_bytes[2*k], cap_bytes[2*k+1]};
                        r.rates = 1'b1;
                    end
                    if (ftype_held[imufp_pkg::TYPE_ANGLES_BIT])
                    begin
                        for (int k = 0; k < 3; k++)
                            held_angle[k] = {cap_bytes[6+2*k], cap_bytes[7+2*k]};
                        r.angles = 1'b1;
                    end
                    good_count = good_count + 16'd1;
                    r.rate_x = held_rate[0];
                    r.rate_y = held_rate[1];
                    r.rate_z = held_rate[2];
                    r.yaw    = held_angle[0];
                    r.roll   = held_angle[1];
                    r.pitch  = held_angle[2];
                    r.count  = good_count;
                    expected_frames.push_back(r);
                end
            end
            default:
                ph = PH_HUNT1;
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int idx,
                               input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
            note_mismatch($sformatf("frame %0d %s: expected %h, actual %h",
                                    idx, name, want, got));
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (expected_frames.size() == 0)
                note_mismatch($sformatf("unexpected frame beat, good_frames %h",
                                        frame_ch.good_frames));
            else
            begin
                want = expected_frames.pop_front();
                check_field("rates_updated", frames_seen, 16'(want.rates),
                            16'(frame_ch.rates_updated));
                check_field("angles_updated", frames_seen, 16'(want.angles),
                            16'(frame_ch.angles_updated));
                check_field("rate_x", frames_seen, want.rate_x, frame_ch.rate_x);
                check_field("rate_y", frames_seen, want.rate_y, frame_ch.rate_y);
                check_field("rate_z", frames_seen, want.rate_z, frame_ch.rate_z);
                check_field("yaw_centideg", frames_seen, want.yaw,
                            frame_ch.yaw_centideg);
                check_field("roll_centideg", frames_seen, want.roll,
                            frame_ch.roll_centideg);
                check_field("pitch_centideg", frames_seen, want.pitch,
                            frame_ch.pitch_centideg);
                check_field("good_frames", frames_seen, want.count,
                            frame_ch.good_frames);
            end
            frames_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    always @(negedge clk)
    begin
        frame_ch.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : watchdog
        repeat (LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
        end
        @(negedge clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] sv;
        sv  = sync_cfg;
        sum = sv + sv + ftype + flen;
        send_byte(sv);
        send_byte(sv);
        send_byte(ftype);
        send_byte(flen);
        if (int'(flen) <= MAX_LEN)
        begin
            for (int i = 0; i < int'(flen); i++)
            begin
                send_byte(body_buf[i]);
                sum = sum + body_buf[i];
            end
            if (corrupt)
                sum = sum ^ 8'($urandom_range(1, 255));
            send_byte(sum);
        end
    endtask

    function void load_body(input logic [MAX_LEN*8-1:0] bytes);
        for (int i = 0; i < MAX_LEN; i++)
            body_buf[i] = bytes[MAX_LEN*8-1-8*i -: 8];
    endfunction

    function void random_body();
        for (int i = 0; i < MAX_LEN; i++)
            body_buf[i] = 8'($urandom);
    endfunction

    task automatic wait_drain();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
    endtask

    // drive the parser back to sync hunt without making a result
    task automatic return_to_hunt();
        while (ph != PH_HUNT1)
        begin
            case (ph)
                PH_LEN:   send_byte(8'hFF);
                PH_CHECK: send_byte(~csum);
                default:  send_byte(sync_cfg ^ 8'h01);
            endcase
        end
    endtask

    task automatic write_sync(input logic [7:0] value);
        logic [DATA_W-1:0] rd;
        return_to_hunt();
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SYNC_ADDR;
        pwdata  <= {24'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sync_cfg = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== DATA_W'(value))
            note_mismatch($sformatf("sync_value readback: expected %h, actual %h",
                                    DATA_W'(value), rd));
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed_frames();
        set_idling(0, 0);
        load_body(128'h8000_7FFF_0000_FFFF_8000_7FFF_0000_0000);
        send_frame(8'h0C, 8'd12, 1'b0);
        load_body(128'h7FFF_8000_FFFF_0000_7FFF_8000_1234_5678);
        send_frame(8'h0C, 8'd16, 1'b0);
        load_body(128'hABCD_EF11_2233_4455_6677_8899_AABB_CCDD);
        send_frame(8'h04, 8'd3, 1'b0);
        send_frame(8'h08, 8'd7, 1'b0);
        send_frame(8'h00, 8'd0, 1'b0);
        send_frame(8'hF3, 8'd2, 1'b0);
        load_body('1);
        send_frame(8'hFF, 8'd12, 1'b0);
        send_frame(8'h0C, 8'd12, 1'b1);
        send_frame(8'h0C, 8'd17, 1'b0);
        send_frame(8'h04, 8'd255, 1'b0);
        send_frame(8'h0C, 8'd1, 1'b0);
        // second sync mismatch, then a clean frame
        send_byte(sync_cfg);
        send_byte(8'h00);
        load_body('0);
        send_frame(8'h0C, 8'd12, 1'b0);
        // stray leading sync shifts the header by one byte
        send_byte(sync_cfg);
        send_frame(8'h04, 8'd6, 1'b0);
        return_to_hunt();
        load_body(128'h0102_0304_0506_0708_090A_0B0C_0D0E_0F10);
        send_frame(8'h0C, 8'd16, 1'b0);
        send_frame(8'h04, 8'd0, 1'b0);
        send_frame(8'h08, 8'd0, 1'b0);
        wait_drain();
    endtask

    task automatic test_sync_register();
        logic [7:0] values [3];
        values = '{8'h00, 8'hFF, imufp_pkg::SYNC_RESET};
        set_idling(20, 20);
        foreach (values[v])
        begin
            write_sync(values[v]);
            for (int n = 0; n < 4; n++)
            begin
                random_body();
                send_frame(8'($urandom) | 8'h0C, 8'($urandom_range(0, MAX_LEN)), 1'b0);
            end
            send_frame(8'h0C, 8'd12, 1'b1);
            load_body('0);
            send_frame(8'h0C, 8'd12, 1'b0);
        end
        wait_drain();
    endtask

    task automatic test_backpressure_holdoff();
        set_idling(0, 0);
        @(negedge clk);
        holdoff_left = 400;
        for (int n = 0; n < 30; n++)
        begin
            random_body();
            send_frame(8'($urandom), 8'($urandom_range(0, 2)), 1'b0);
        end
        wait_drain();
    endtask

    task automatic random_phase(input int budget);
        int start;
        int pick;
        logic [7:0] ftype;
        logic [7:0] flen;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
            begin
                random_body();
                ftype = 8'($urandom);
                if ($urandom_range(1))
                    ftype[imufp_pkg::TYPE_ANGLES_BIT:imufp_pkg::TYPE_RATES_BIT] = 2'b11;
                pick = $urandom_range(99);
                if (pick < 10)
                    flen = 8'($urandom_range(MAX_LEN + 1, 255));
                else if (pick < 25)
                    flen = 8'(CAPTURE_LEN);
                else
                    flen = 8'($urandom_range(0, MAX_LEN));
                send_frame(ftype, flen, $urandom_range(99) < 15);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(7) == 0) ? sync_cfg : 8'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 76, 0, 16};
        recv_pct = '{0, 0, 76, 16};
        for (int p = 0; p < 4; p++)
        begin
            write_sync(8'($urandom));
            set_idling(send_pct[p], recv_pct[p]);
            random_phase(110);
            if (p == 1)
                wait_drain();
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        frame_ch.ready = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        frames_seen    = 0;
        reset_tracker();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_sync_register();
        test_backpressure_holdoff();
        test_random_traffic();

        wait_drain();
        repeat (20) @(posedge clk);
        if (expected_frames.size() != 0)
            note_mismatch($sformatf("%0d expected frames never arrived",
                                    expected_frames.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/imufp_pkg.sv
src/imufp_if.sv
src/imufp_fifo.sv
src/imufp_front.sv
src/imufp_back.sv
src/imu_frame_parser_top.sv
src/imufp_chk.sv
dv/tb_top.sv
